/* hdl/pal_pkg.sv */
// Shared types and constants for the positional array list.
// No dependencies; used by every module of the block.
package pal_pkg;

  localparam int MaxEntries = 16;
  localparam int DataW      = 32;
  localparam int CmdW       = 2;
  localparam int PosW       = 4;
  localparam int CapW       = 5;
  localparam int CountW     = 5;
  localparam int StatusW    = 3;

  localparam logic [CapW-1:0] CapacityReset = CapW'(16);

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_POS = 2'd1,
    CMD_REMOVE_VAL = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  removed;
    logic [CountW-1:0]        count;
  } result_t;

endpackage

/* hdl/pal_mem.sv */
// Entry store: one write port, one read port, registered read data.
// Depends on pal_pkg for the data width.
module pal_mem #(
  parameter int MAX_ENTRIES = pal_pkg::MaxEntries
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]   waddr_i,
  input  logic [pal_pkg::DataW-1:0]        wdata_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]   raddr_i,
  output logic [pal_pkg::DataW-1:0]        rdata_o
);

  logic [pal_pkg::DataW-1:0] mem [MAX_ENTRIES];
  logic [pal_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pal_outreg.sv */
// Result register between the sequencer and the output channel.
// Depends on pal_pkg for the result type.
module pal_outreg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  input  pal_pkg::result_t                  res_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pal_pkg::StatusW-1:0]       status_o,
  output logic signed [pal_pkg::DataW-1:0]  removed_value_o,
  output logic [pal_pkg::CountW-1:0]        entry_count_o
);

  logic             valid_q, valid_d;
  pal_pkg::result_t res_q;
  logic             load;

  assign free_o = !valid_q || !out_stall_i;
  assign load   = res_valid_i && free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = res_q.status;
  assign removed_value_o = res_q.removed;
  assign entry_count_o   = res_q.count;

endmodule

/* hdl/pal_seq.sv */
// Command sequencer: checks, shifts entries through the store one per cycle,
// keeps the count and the capacity register. Depends on pal_pkg.
module pal_seq #(
  parameter int MAX_ENTRIES = pal_pkg::MaxEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [pal_pkg::CapW-1:0]            cfg_capacity_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pal_pkg::CmdW-1:0]            cmd_i,
  input  logic signed [pal_pkg::DataW-1:0]    value_i,
  input  logic [pal_pkg::PosW-1:0]            position_i,
  output logic                                mem_we_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]      mem_waddr_o,
  output logic [pal_pkg::DataW-1:0]           mem_wdata_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]      mem_raddr_o,
  input  logic [pal_pkg::DataW-1:0]           mem_rdata_i,
  output logic                                res_valid_o,
  output pal_pkg::result_t                    res_o,
  input  logic                                out_free_i
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > pal_pkg::CapW) ? CW : pal_pkg::CapW;

  pal_pkg::state_e  state_q, state_d;
  pal_pkg::cmd_e    cmd_q, cmd_d;
  pal_pkg::status_e status_q, status_d;
  logic [pal_pkg::DataW-1:0] val_q, val_d;
  logic [pal_pkg::DataW-1:0] removed_q, removed_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [pal_pkg::CapW-1:0] cap_q, cap_d;
  logic            rd_pend_q, rd_pend_d;
  logic            hole_q, hole_d;
  logic            ok_q, ok_d;

  logic            in_acc, done, rd_issue, match, full;
  logic [CMPW-1:0] posw, cntw, capw, maxw;

  assign in_stall_o = (state_q != pal_pkg::S_IDLE);
  assign in_acc     = in_valid_i && (state_q == pal_pkg::S_IDLE);

  assign posw = CMPW'(position_i);
  assign cntw = CMPW'(cnt_q);
  assign capw = CMPW'(cap_q);
  assign maxw = CMPW'(MAX_ENTRIES);
  assign full = (cntw >= capw) || (cntw >= maxw);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pal_pkg::S_IDLE: if (in_acc) state_d = pal_pkg::S_RUN;
      pal_pkg::S_RUN:  if (done) state_d = pal_pkg::S_DONE;
      pal_pkg::S_DONE: if (out_free_i) state_d = pal_pkg::S_IDLE;
      default:         state_d = pal_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    status_d    = status_q;
    val_d       = val_q;
    removed_d   = removed_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    hole_d      = hole_q;
    ok_d        = ok_q;
    cap_d       = cfg_valid_i ? cfg_capacity_i : cap_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = rd_idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = IW'(ptr_q);
    rd_issue    = 1'b0;
    match       = 1'b0;
    done        = 1'b0;
    res_valid_o = 1'b0;

    if (in_acc) begin
      cmd_d     = pal_pkg::cmd_e'(cmd_i);
      val_d     = value_i;
      pos_d     = IW'(position_i);
      removed_d = '0;
      hole_d    = 1'b0;
      status_d  = pal_pkg::ST_OK;
      ok_d      = 1'b0;
      ptr_d     = cnt_q;
      unique case (pal_pkg::cmd_e'(cmd_i))
        pal_pkg::CMD_INSERT: begin
          priority if (full) status_d = pal_pkg::ST_FULL;
          else if (posw > cntw) status_d = pal_pkg::ST_BADPOS;
          else ok_d = 1'b1;
        end
        pal_pkg::CMD_REMOVE_POS: begin
          priority if (cnt_q == '0) status_d = pal_pkg::ST_EMPTY;
          else if (posw >= cntw) status_d = pal_pkg::ST_BADPOS;
          else begin
            ok_d  = 1'b1;
            ptr_d = CW'(position_i);
          end
        end
        pal_pkg::CMD_REMOVE_VAL: begin
          if (cnt_q == '0) begin
            status_d = pal_pkg::ST_EMPTY;
          end else begin
            ok_d  = 1'b1;
            ptr_d = '0;
          end
        end
        pal_pkg::CMD_NOP: ok_d = 1'b0;
        default:          ok_d = 1'b0;
      endcase
    end

    if (state_q == pal_pkg::S_RUN) begin
      if (!ok_q) begin
        done = 1'b1;
      end else if (cmd_q == pal_pkg::CMD_INSERT) begin
        // walk down from the top, moving each entry up by one
        rd_issue    = (ptr_q > CW'(pos_q));
        mem_raddr_o = IW'(ptr_q - CW'(1));
        if (rd_issue) ptr_d = ptr_q - CW'(1);
        if (rd_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = rd_idx_q + IW'(1);
          mem_wdata_o = mem_rdata_i;
        end else if (!rd_issue) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q;
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CW'(1);
          done        = 1'b1;
        end
      end else begin
        // walk up, find the hole, then move each later entry down by one
        rd_issue    = (ptr_q < cnt_q);
        mem_raddr_o = IW'(ptr_q);
        if (rd_issue) ptr_d = ptr_q + CW'(1);
        match = (cmd_q == pal_pkg::CMD_REMOVE_POS) ? (rd_idx_q == pos_q)
                                                   : (mem_rdata_i == val_q);
        if (rd_pend_q) begin
          if (hole_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = rd_idx_q - IW'(1);
            mem_wdata_o = mem_rdata_i;
          end else if (match) begin
            hole_d    = 1'b1;
            removed_d = mem_rdata_i;
          end
        end else if (!rd_issue) begin
          done = 1'b1;
          if (hole_q) cnt_d = cnt_q - CW'(1);
          else status_d = pal_pkg::ST_NOTFOUND;
        end
      end
    end

    if (state_q == pal_pkg::S_DONE) begin
      res_valid_o = 1'b1;
    end
  end

  assign rd_pend_d = (state_q == pal_pkg::S_RUN) && ok_q && rd_issue;
  assign rd_idx_d  = mem_raddr_o;

  assign res_o.status  = status_q;
  assign res_o.removed = removed_q;
  assign res_o.count   = pal_pkg::CountW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pal_pkg::S_IDLE;
      cnt_q     <= '0;
      cap_q     <= pal_pkg::CapacityReset;
      rd_pend_q <= 1'b0;
      hole_q    <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cap_q     <= cap_d;
      rd_pend_q <= rd_pend_d;
      hole_q    <= hole_d;
      ok_q      <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    status_q  <= status_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    pos_q     <= pos_d;
    ptr_q     <= ptr_d;
    rd_idx_q  <= rd_idx_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && rd_pend_d) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same entry in one cycle");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q + CW'(1) == $past(cnt_q))))
    else $error("entry count moved by more than one");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pal_pkg::S_IDLE) |-> (!rd_pend_q && !mem_we_o))
    else $error("store access outside a command");

  a_cnt_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (state_q == pal_pkg::S_DONE))
    else $error("entry count changed before the command finished");
`endif

endmodule

/* hdl/positional_array_list.sv */
// Positional array list: ordered list of signed words held in a memory.
// Channels: input items (cmd_i, value_i, position_i) under in_valid_i and
// in_stall_o; result items (status_o, removed_value_o, entry_count_o) under
// out_valid_o and out_stall_i; an item moves when valid is high and stall
// is low. cfg_valid_i/cfg_ready_o write the capacity register; the user must do so
// only while no command is in flight, as the block itself does not enforce it.
// Each command is run by a sequencer that moves entries through the store
// one per cycle on its single read port. It reads the entries above the
// position for insert, and from the start point up to the count for
// removals; an insert at the end and failed or ignored commands read
// nothing. A new command is accepted only once the sequencer is back in
// idle after the previous one. The result passes from the run state
// through the done state into the output register.
// A finished result sits in an output register, so the sequencer may take
// the next item while it waits; a stalled receiver holds the result and,
// once the sequencer has a further result ready, holds the input too.
// Reset empties the list and sets capacity to 16; the store itself is not
// cleared, as no entry is read before it is written.
// Depends on pal_pkg, pal_mem, pal_seq and pal_outreg.
module positional_array_list #(
  parameter int MAX_ENTRIES = pal_pkg::MaxEntries
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pal_pkg::CapW-1:0]           cfg_capacity_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pal_pkg::CmdW-1:0]           cmd_i,
  input  logic signed [pal_pkg::DataW-1:0]   value_i,
  input  logic [pal_pkg::PosW-1:0]           position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pal_pkg::StatusW-1:0]        status_o,
  output logic signed [pal_pkg::DataW-1:0]   removed_value_o,
  output logic [pal_pkg::CountW-1:0]         entry_count_o
);

  localparam int IW = $clog2(MAX_ENTRIES);

  logic                      mem_we;
  logic [IW-1:0]             mem_waddr, mem_raddr;
  logic [pal_pkg::DataW-1:0] mem_wdata, mem_rdata;
  logic                      res_valid, out_free;
  pal_pkg::result_t          res;

  assign cfg_ready_o = 1'b1;

  pal_mem #(.MAX_ENTRIES(MAX_ENTRIES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pal_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .out_free_i     (out_free)
  );

  pal_outreg u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

/* tb/tb.sv */
// Testbench for positional_array_list: directed table, then random phases with idling,
// stalls and a long output hold-off; results checked against the table or an in-bench list model.
// Depends on pal_pkg and positional_array_list.
`timescale 1ns / 100ps

module tb;

  localparam int HoldCycles    = 150;
  localparam int PressurePhase = 4;
  localparam int SettleCycles  = 20;
  localparam int NumPhases     = 7;
  localparam int NumDirected   = 27;

  typedef struct packed {
    bit               is_cfg;
    pal_pkg::cmd_e    cmd;
    logic [31:0]      value;
    logic [3:0]       pos;
    bit               typed;
    pal_pkg::result_t want;
  } step_t;

  localparam pal_pkg::result_t NoWant = '{pal_pkg::ST_OK, 32'sh0, 5'd0};

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [pal_pkg::CapW-1:0]          cfg_capacity_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [pal_pkg::CmdW-1:0]          cmd_i = pal_pkg::CMD_NOP;
  logic signed [pal_pkg::DataW-1:0]  value_i = '0;
  logic [pal_pkg::PosW-1:0]          position_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [pal_pkg::StatusW-1:0]       status_o;
  logic signed [pal_pkg::DataW-1:0]  removed_value_o;
  logic [pal_pkg::CountW-1:0]        entry_count_o;

  // list model
  logic signed [pal_pkg::DataW-1:0]  list_mem [pal_pkg::MaxEntries];
  int                                list_len = 0;
  logic [pal_pkg::CapW-1:0]          list_cap = pal_pkg::CapacityReset;
  pal_pkg::result_t                  pending_results [$];

  int errors      = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  int ph_send  [NumPhases] = '{0, 87, 0, 31, 0, 31, 0};
  int ph_stall [NumPhases] = '{0, 0, 87, 31, 0, 31, 0};
  int ph_cap   [NumPhases] = '{16, 1, 8, 31, 16, 0, 16};
  int ph_ins   [NumPhases] = '{60, 50, 70, 55, 80, 40, 50};
  int ph_items [NumPhases] = '{90, 70, 80, 90, 60, 40, 70};

  step_t directed [NumDirected] = '{
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd0, 1'b1, '{pal_pkg::ST_EMPTY, 32'sh0, 5'd0}},
    '{1'b0, pal_pkg::CMD_REMOVE_VAL, 32'h5, 4'd0, 1'b1, '{pal_pkg::ST_EMPTY, 32'sh0, 5'd0}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h7, 4'd1, 1'b1, '{pal_pkg::ST_BADPOS, 32'sh0, 5'd0}},
    '{1'b0, pal_pkg::CMD_NOP, 32'hffffffff, 4'd15, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd0}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h7fffffff, 4'd0, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd1}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h80000000, 4'd0, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd2}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'hffffffff, 4'd2, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd3}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h0, 4'd1, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd4}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h1, 4'd5, 1'b1, '{pal_pkg::ST_BADPOS, 32'sh0, 5'd4}},
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd4, 1'b1, '{pal_pkg::ST_BADPOS, 32'sh0, 5'd4}},
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd15, 1'b1, '{pal_pkg::ST_BADPOS, 32'sh0, 5'd4}},
    '{1'b0, pal_pkg::CMD_REMOVE_VAL, 32'd12345, 4'd0, 1'b1,
      '{pal_pkg::ST_NOTFOUND, 32'sh0, 5'd4}},
    '{1'b0, pal_pkg::CMD_REMOVE_VAL, 32'h0, 4'd0, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd3}},
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd0, 1'b1,
      '{pal_pkg::ST_OK, 32'sh80000000, 5'd2}},
    '{1'b0, pal_pkg::CMD_INSERT, 32'hffffffff, 4'd1, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h55555555, 4'd3, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_REMOVE_VAL, 32'hffffffff, 4'd0, 1'b0, NoWant},
    '{1'b1, pal_pkg::CMD_NOP, 32'd2, 4'd0, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_INSERT, 32'haaaaaaaa, 4'd0, 1'b1, '{pal_pkg::ST_FULL, 32'sh0, 5'd3}},
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd2, 1'b0, NoWant},
    '{1'b1, pal_pkg::CMD_NOP, 32'd0, 4'd0, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_INSERT, 32'h1, 4'd0, 1'b1, '{pal_pkg::ST_FULL, 32'sh0, 5'd2}},
    '{1'b0, pal_pkg::CMD_NOP, 32'h0, 4'd0, 1'b1, '{pal_pkg::ST_OK, 32'sh0, 5'd2}},
    '{1'b1, pal_pkg::CMD_NOP, 32'd31, 4'd0, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_INSERT, 32'haaaaaaaa, 4'd2, 1'b0, NoWant},
    '{1'b0, pal_pkg::CMD_REMOVE_POS, 32'h0, 4'd1, 1'b0, NoWant},
    '{1'b1, pal_pkg::CMD_NOP, 32'd16, 4'd0, 1'b0, NoWant}
  };

  positional_array_list i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_capacity_i  (cfg_capacity_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic pal_pkg::result_t apply_command(pal_pkg::cmd_e c,
                                                     logic signed [pal_pkg::DataW-1:0] v,
                                                     logic [pal_pkg::PosW-1:0] p);
    pal_pkg::result_t r;
    int               eff;
    int               hit;
    int               i;
    r   = NoWant;
    hit = -1;
    eff = (list_cap > pal_pkg::MaxEntries) ? pal_pkg::MaxEntries : int'(list_cap);
    case (c)
      pal_pkg::CMD_INSERT: begin
        if (list_len >= eff) r.status = pal_pkg::ST_FULL;
        else if (int'(p) > list_len) r.status = pal_pkg::ST_BADPOS;
        else begin
          for (i = list_len; i > int'(p); i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = v;
          list_len++;
        end
      end
      pal_pkg::CMD_REMOVE_POS: begin
        if (list_len == 0) r.status = pal_pkg::ST_EMPTY;
        else if (int'(p) >= list_len) r.status = pal_pkg::ST_BADPOS;
        else hit = int'(p);
      end
      pal_pkg::CMD_REMOVE_VAL: begin
        if (list_len == 0) r.status = pal_pkg::ST_EMPTY;
        else begin
          for (i = 0; i < list_len && hit < 0; i++) if (list_mem[i] == v) hit = i;
          if (hit < 0) r.status = pal_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.removed = list_mem[hit];
      for (i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
      list_len--;
    end
    r.count = pal_pkg::CountW'(list_len);
    return r;
  endfunction

  task automatic offer(pal_pkg::cmd_e c, logic [pal_pkg::DataW-1:0] v,
                       logic [pal_pkg::PosW-1:0] p, bit typed, pal_pkg::result_t want);
    pal_pkg::result_t r;
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_command(c, v, p);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic pause_sender(int idle_pct, bit last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0 || last) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [pal_pkg::CapW-1:0] cap);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    list_cap = cap;
  endtask

  task automatic random_command(int ins_w);
    pal_pkg::cmd_e             c;
    logic [pal_pkg::DataW-1:0] v;
    logic [pal_pkg::PosW-1:0]  p;
    int                        r;
    int                        sel;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (r < ins_w) c = pal_pkg::CMD_INSERT;
    else if (r >= 97) c = pal_pkg::CMD_NOP;
    else if ($urandom_range(0, 1)) c = pal_pkg::CMD_REMOVE_POS;
    else c = pal_pkg::CMD_REMOVE_VAL;
    if (sel < 3) v = $urandom;
    else if (sel < 6 || list_len == 0) v = $urandom_range(0, 6) - 3;
    else v = list_mem[$urandom_range(0, list_len - 1)];
    if ($urandom_range(0, 9) == 0) p = pal_pkg::PosW'($urandom_range(0, 15));
    else if (c == pal_pkg::CMD_INSERT)
      p = pal_pkg::PosW'($urandom_range(0, (list_len > 15) ? 15 : list_len));
    else if (list_len > 0) p = pal_pkg::PosW'($urandom_range(0, list_len - 1));
    else p = pal_pkg::PosW'($urandom_range(0, 15));
    offer(c, v, p, 1'b0, NoWant);
  endtask

  // output side: random stalls plus one long hold-off in the pressure phase
  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    pal_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item: status %0d removed %0d count %0d", $time,
                 status_o, removed_value_o, entry_count_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          errors++;
        end
        if (removed_value_o !== want.removed) begin
          $display("%0t: removed value expected %0d got %0d", $time, want.removed,
                   removed_value_o);
          errors++;
        end
        if (entry_count_o !== want.count) begin
          $display("%0t: count expected %0d got %0d", $time, want.count, entry_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int ph;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NumDirected; n++) begin
      if (directed[n].is_cfg) begin
        set_capacity(directed[n].value[pal_pkg::CapW-1:0]);
      end else begin
        offer(directed[n].cmd, directed[n].value, directed[n].pos, directed[n].typed,
              directed[n].want);
        pause_sender(0, (n + 1 == NumDirected) || directed[n+1].is_cfg);
      end
    end

    ph_cap[NumPhases-1] = $urandom_range(1, 16);
    for (ph = 0; ph < NumPhases; ph++) begin
      set_capacity(ph_cap[ph][pal_pkg::CapW-1:0]);
      stall_pct = ph_stall[ph];
      if (ph == PressurePhase) hold_asked++;
      for (n = 0; n < ph_items[ph]; n++) begin
        random_command(ph_ins[ph]);
        pause_sender(ph_send[ph], n == ph_items[ph] - 1);
      end
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
